[src/gtli_pkg.sv]
// shared types and codes of the gain table level interpolator
`timescale 1ns / 1ps
package gtli_pkg;

    // fixed field widths
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 5;
    localparam int DEN_W  = 17;
    localparam int PROD_W = 34;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_LOOKUP  = 2'd0,
        OP_WR_GAIN = 2'd1,
        OP_WR_BP   = 2'd2,
        OP_UNKNOWN = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_DEGEN = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic [1:0] CFG_LEVELS   = 2'd0;
    localparam logic [1:0] CFG_BANDS    = 2'd1;
    localparam logic [1:0] CFG_CHANNELS = 2'd2;

    // item class decided by the front part
    typedef enum logic [2:0] {
        K_LOOKUP  = 3'd0,
        K_SINGLE  = 3'd1,
        K_WR_GAIN = 3'd2,
        K_WR_BP   = 3'd3,
        K_ERR     = 3'd4
    } t_kind;

    // queue entry between front and back
    typedef struct packed {
        t_kind                    kind;
        logic                     ch;
        logic [3:0]               band;
        logic [3:0]               lvl;
        logic signed [VAL_W-1:0]  val;
        logic [CNT_W-1:0]         nl;
    } t_entry;

endpackage

[src/gtli_front.sv]
// front part: configuration registers, item acceptance and classification
`timescale 1ns / 1ps
module gtli_front import gtli_pkg::*; #(
    parameter int MAX_CHANNELS = 2,
    parameter int MAX_BANDS    = 16,
    parameter int MAX_LEVELS   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [1:0]              i_operation,
    input  logic                    i_channel,
    input  logic [3:0]              i_band,
    input  logic [3:0]              i_level_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    output logic                    o_push,
    output t_entry                  o_entry
);

    logic [CNT_W-1:0] r_levels;
    logic [CNT_W-1:0] r_bands;
    logic [1:0]       r_channels;
    logic [CNT_W-1:0] nl;
    logic [CNT_W-1:0] nb;
    logic [1:0]       nc;
    logic             ch_bad;
    logic             band_bad;
    logic             lvl_bad;
    t_kind            kind;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels   <= CNT_W'(16);
            r_bands    <= CNT_W'(16);
            r_channels <= 2'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEVELS:   r_levels   <= i_cfg_wdata;
                CFG_BANDS:    r_bands    <= i_cfg_wdata;
                CFG_CHANNELS: r_channels <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // in-use counts clamped to 1..max
    always_comb begin
        if (r_levels == '0) nl = CNT_W'(1);
        else if (int'(r_levels) > MAX_LEVELS) nl = CNT_W'(MAX_LEVELS);
        else nl = r_levels;
        if (r_bands == '0) nb = CNT_W'(1);
        else if (int'(r_bands) > MAX_BANDS) nb = CNT_W'(MAX_BANDS);
        else nb = r_bands;
        if (r_channels == '0) nc = 2'd1;
        else if (int'(r_channels) > MAX_CHANNELS) nc = 2'(MAX_CHANNELS);
        else nc = r_channels;
    end

    // range checks and classification
    always_comb begin
        ch_bad   = int'(i_channel) >= int'(nc);
        band_bad = int'(i_band) >= int'(nb);
        lvl_bad  = int'(i_level_index) >= int'(nl);
        unique case (t_op'(i_operation))
            OP_LOOKUP:  kind = (ch_bad || band_bad) ? K_ERR :
                               ((nl == CNT_W'(1)) ? K_SINGLE : K_LOOKUP);
            OP_WR_GAIN: kind = (ch_bad || band_bad || lvl_bad) ? K_ERR : K_WR_GAIN;
            OP_WR_BP:   kind = lvl_bad ? K_ERR : K_WR_BP;
            OP_UNKNOWN: kind = K_ERR;
        endcase
    end

    assign o_push        = i_start && !i_busy;
    assign o_entry.kind  = kind;
    assign o_entry.ch    = i_channel;
    assign o_entry.band  = i_band;
    assign o_entry.lvl   = i_level_index;
    assign o_entry.val   = i_value;
    assign o_entry.nl    = nl;

endmodule

[src/gtli_queue.sv]
// two-entry item queue between front and back
`timescale 1ns / 1ps
module gtli_queue import gtli_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty,
    output logic   o_full
);

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_entry = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

[src/gtli_div.sv]
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
module gtli_div import gtli_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [PROD_W-1:0] i_num,
    input  logic signed [DEN_W-1:0]  i_den,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_quo
);

    localparam int IT_W = $clog2(PROD_W);

    logic               r_busy;
    logic               r_done;
    logic [IT_W-1:0]    r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [PROD_W-1:0]  r_q;
    logic [DEN_W-1:0]   r_d;
    logic               r_neg;
    logic [DEN_W:0]     shifted;
    logic               ge;

    // restoring step
    always_comb begin
        shifted = {r_rem, r_q[PROD_W-1]};
        ge      = shifted >= {1'b0, r_d};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[PROD_W-1] ? PROD_W'(-i_num) : PROD_W'(i_num);
            r_d   <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            r_neg <= i_num[PROD_W-1] ^ i_den[DEN_W-1];
            r_rem <= '0;
            r_cnt <= IT_W'(PROD_W - 1);
        end else if (r_busy) begin
            r_rem <= ge ? DEN_W'(shifted - {1'b0, r_d}) : shifted[DEN_W-1:0];
            r_q   <= {r_q[PROD_W-2:0], ge};
            r_cnt <= r_cnt - IT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? $signed(-r_q) : $signed(r_q);

endmodule

[src/gtli_back.sv]
// back part: table memories, breakpoint search and interpolation sequencer
`timescale 1ns / 1ps
module gtli_back import gtli_pkg::*; #(
    parameter int MAX_CHANNELS = 2,
    parameter int MAX_BANDS    = 16,
    parameter int MAX_LEVELS   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  t_entry                  i_entry,
    output logic                    o_pop,
    output logic                    o_clearing,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_gain,
    output logic [1:0]              o_status
);

    localparam int IW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int GDEPTH = MAX_CHANNELS * MAX_BANDS * MAX_LEVELS;
    localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int CW     = $clog2(GDEPTH + 1);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_EXEC  = 11'b00000000100,
        S_SCAN  = 11'b00000001000,
        S_RDI   = 11'b00000010000,
        S_RDN   = 11'b00000100000,
        S_CAPN  = 11'b00001000000,
        S_MUL   = 11'b00010000000,
        S_DST   = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_SGL   = 11'b10000000000
    } t_state;

    t_state                   r_state;
    t_entry                   r_e;
    logic [CW-1:0]            r_clr;
    logic [IW-1:0]            r_ka;
    logic [IW-1:0]            r_kd;
    logic                     r_dv;
    logic [IW-1:0]            r_i;
    logic [IW-1:0]            r_n;
    logic signed [VAL_W-1:0]  r_x;
    logic signed [VAL_W-1:0]  r_y;
    logic signed [VAL_W-1:0]  r_yn;
    logic signed [DEN_W-1:0]  r_den;
    logic signed [DEN_W-1:0]  r_dx;
    logic signed [DEN_W-1:0]  r_dy;
    logic signed [PROD_W-1:0] r_num;
    logic                     r_done;
    logic signed [VAL_W-1:0]  r_gain;
    t_status                  r_status;

    logic signed [VAL_W-1:0]  r_gmem [GDEPTH];
    logic signed [VAL_W-1:0]  r_grd;
    logic signed [VAL_W-1:0]  r_bmem [MAX_LEVELS];
    logic signed [VAL_W-1:0]  r_brd;

    logic                     g_we;
    logic [GAW-1:0]           g_waddr;
    logic [GAW-1:0]           g_raddr;
    logic signed [VAL_W-1:0]  g_wdata;
    logic                     b_we;
    logic [IW-1:0]            b_waddr;
    logic [IW-1:0]            b_raddr;
    logic signed [VAL_W-1:0]  b_wdata;
    logic [IW-1:0]            last;
    int                       row;
    logic                     div_done;
    logic signed [PROD_W-1:0] div_quo;
    logic signed [PROD_W:0]   sum;

    // gain table memory
    always_ff @(posedge i_clk) begin
        if (g_we) r_gmem[g_waddr] <= g_wdata;
        r_grd <= r_gmem[g_raddr];
    end

    // breakpoint memory
    always_ff @(posedge i_clk) begin
        if (b_we) r_bmem[b_waddr] <= b_wdata;
        r_brd <= r_bmem[b_raddr];
    end

    // memory addressing
    always_comb begin
        row     = int'(r_e.ch) * MAX_BANDS + int'(r_e.band);
        last    = IW'(r_e.nl - CNT_W'(1));
        g_we    = (r_state == S_CLEAR) || (r_state == S_EXEC && r_e.kind == K_WR_GAIN);
        g_waddr = (r_state == S_CLEAR) ? r_clr[GAW-1:0]
                                       : GAW'(row * MAX_LEVELS + int'(r_e.lvl));
        g_wdata = (r_state == S_CLEAR) ? '0 : r_e.val;
        b_we    = (r_state == S_CLEAR && int'(r_clr) < MAX_LEVELS) ||
                  (r_state == S_EXEC && r_e.kind == K_WR_BP);
        b_waddr = (r_state == S_CLEAR) ? r_clr[IW-1:0] : IW'(r_e.lvl);
        b_wdata = (r_state == S_CLEAR) ? '0 : r_e.val;
        if (r_state == S_RDN) begin
            g_raddr = GAW'(row * MAX_LEVELS + int'(r_n));
            b_raddr = r_n;
        end else if (r_state == S_RDI) begin
            g_raddr = GAW'(row * MAX_LEVELS + int'(r_i));
            b_raddr = r_i;
        end else begin
            g_raddr = GAW'(row * MAX_LEVELS);
            b_raddr = r_ka;
        end
    end

    // final sum, saturated by the sequencer
    assign sum = (PROD_W+1)'(r_yn) + (PROD_W+1)'(div_quo);

    gtli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DST),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (int'(r_clr) == GDEPTH - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_e     <= i_entry;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_e.kind)
                        K_LOOKUP: begin
                            r_ka    <= '0;
                            r_dv    <= 1'b0;
                            r_state <= S_SCAN;
                        end
                        K_SINGLE: r_state <= S_SGL;
                        K_WR_GAIN, K_WR_BP: begin
                            r_done   <= 1'b1;
                            r_gain   <= '0;
                            r_status <= ST_OK;
                            r_state  <= S_IDLE;
                        end
                        default: begin
                            r_done   <= 1'b1;
                            r_gain   <= '0;
                            r_status <= ST_RANGE;
                            r_state  <= S_IDLE;
                        end
                    endcase
                end
                S_SCAN: begin
                    r_kd <= r_ka;
                    r_dv <= 1'b1;
                    if (r_ka != last) r_ka <= r_ka + IW'(1);
                    if (r_dv && (!(r_brd < r_e.val) || r_kd == last)) begin
                        r_i     <= r_kd;
                        r_n     <= (r_kd == '0) ? IW'(1) : r_kd - IW'(1);
                        r_state <= S_RDI;
                    end
                end
                S_RDI: r_state <= S_RDN;
                S_RDN: begin
                    r_x     <= r_brd;
                    r_y     <= r_grd;
                    r_state <= S_CAPN;
                end
                S_CAPN: begin
                    r_yn    <= r_grd;
                    r_den   <= {r_x[VAL_W-1], r_x} - {r_brd[VAL_W-1], r_brd};
                    r_dx    <= {r_e.val[VAL_W-1], r_e.val} - {r_brd[VAL_W-1], r_brd};
                    r_dy    <= {r_y[VAL_W-1], r_y} - {r_grd[VAL_W-1], r_grd};
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_den == '0) begin
                        r_done   <= 1'b1;
                        r_gain   <= r_yn;
                        r_status <= ST_DEGEN;
                        r_state  <= S_IDLE;
                    end else begin
                        r_num   <= PROD_W'(r_dy) * PROD_W'(r_dx);
                        r_state <= S_DST;
                    end
                end
                S_DST: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (sum > (PROD_W+1)'(32767)) begin
                            r_gain   <= 16'sh7FFF;
                            r_status <= ST_SAT;
                        end else if (sum < -(PROD_W+1)'(32768)) begin
                            r_gain   <= -16'sh8000;
                            r_status <= ST_SAT;
                        end else begin
                            r_gain   <= sum[VAL_W-1:0];
                            r_status <= ST_OK;
                        end
                    end
                end
                S_SGL: begin
                    r_done   <= 1'b1;
                    r_gain   <= r_grd;
                    r_status <= ST_OK;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_done     = r_done;
    assign o_gain     = r_gain;
    assign o_status   = r_status;

    // no result leaves while the tables are being cleared
    a_no_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_done) else $error("result during clearing pass");

    // no two results come back to back
    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("back-to-back results");

    // a saturated result sits on a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_SAT) |-> (o_gain == 16'sh7FFF || o_gain == -16'sh8000))
        else $error("saturated gain not at a bound");

    // a rejected item returns zero gain
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_RANGE) |-> (o_gain == '0))
        else $error("range error with nonzero gain");

endmodule

[src/gain_table_level_interpolator_top.sv]
// top level of the gain table level interpolator
//
//  channel  direction  signals                                        handshake
//  item     in         i_operation i_channel i_band i_level_index     start && !busy
//                      i_value
//  result   out        o_gain o_status                                o_done, one cycle
//  config   in         i_cfg_idx i_cfg_wdata                          i_cfg_we
//
//  writes and rejected items finish after pop and dispatch, one-level lookups after
//  a further gain read; an interpolated lookup runs pop and dispatch, a breakpoint
//  scan, reads, multiply and divider start, the one-bit-per-cycle divider and a
//  result step; a degenerate interval ends at the multiply step without the divider
//  after reset a clearing pass over MAX_CHANNELS*MAX_BANDS*MAX_LEVELS gain entries
//  (512 by default) holds busy high; configuration writes are taken throughout
//  busy also rises when the two-entry queue is full; results are never held back
`timescale 1ns / 1ps
module gain_table_level_interpolator_top import gtli_pkg::*; #(
    parameter int MAX_CHANNELS = 2,
    parameter int MAX_BANDS    = 16,
    parameter int MAX_LEVELS   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_operation,
    input  logic                    i_channel,
    input  logic [3:0]              i_band,
    input  logic [3:0]              i_level_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_gain,
    output logic [1:0]              o_status
);

    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;
    logic   clearing;
    t_entry f_entry;
    t_entry q_entry;

    // busy while the queue is full or the tables are clearing
    assign busy = q_full || clearing;

    gtli_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_BANDS    (MAX_BANDS),
        .MAX_LEVELS   (MAX_LEVELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_channel     (i_channel),
        .i_band        (i_band),
        .i_level_index (i_level_index),
        .i_value       (i_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_push        (push),
        .o_entry       (f_entry)
    );

    gtli_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    gtli_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_BANDS    (MAX_BANDS),
        .MAX_LEVELS   (MAX_LEVELS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_entry    (q_entry),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_done     (o_done),
        .o_gain     (o_gain),
        .o_status   (o_status)
    );

endmodule

[dv/gtli_checker.sv]
// checker of the gain table level interpolator: predicts and compares every result
`timescale 1ns / 1ps
module gtli_checker import gtli_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [1:0]              i_operation,
    input  logic                    i_channel,
    input  logic [3:0]              i_band,
    input  logic [3:0]              i_level_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    input  logic                    i_done,
    input  logic signed [VAL_W-1:0] i_gain,
    input  logic [1:0]              i_status,
    output int                      o_errors,
    output int                      o_pending
);

    typedef struct {
        logic signed [15:0] gain;
        t_status            status;
    } t_result;

    logic signed [15:0] gain_mem [512];
    logic signed [15:0] bp_mem [16];
    logic [4:0]         levels_cfg, bands_cfg;
    logic [1:0]         chans_cfg;
    t_result            expected_q [$];
    int                 err_cnt;

    assign o_errors  = err_cnt;
    assign o_pending = expected_q.size();

    function automatic int clamp_cnt(int v, int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // apply one item to the shadow tables and return its result
    function automatic t_result interpolate_item(t_op op, int ch, int bd, int lv,
                                                 logic signed [15:0] v);
        t_result r;
        int nl, nb, nc, idx, nbr;
        longint x, xn, y, yn, den, q, g;
        nl = clamp_cnt(levels_cfg, 16);
        nb = clamp_cnt(bands_cfg, 16);
        nc = clamp_cnt(chans_cfg, 2);
        r.gain = '0;
        r.status = ST_OK;
        case (op)
            OP_LOOKUP: begin
                if (ch >= nc || bd >= nb) begin
                    r.status = ST_RANGE;
                end else if (nl == 1) begin
                    r.gain = gain_mem[(ch*16+bd)*16];
                end else begin
                    idx = 0;
                    while (idx < nl && bp_mem[idx] < v) idx++;
                    if (idx >= nl) idx = nl - 1;
                    nbr = (idx == 0) ? 1 : idx - 1;
                    x = bp_mem[idx];
                    xn = bp_mem[nbr];
                    y = gain_mem[(ch*16+bd)*16+idx];
                    yn = gain_mem[(ch*16+bd)*16+nbr];
                    den = x - xn;
                    if (den == 0) begin
                        r.gain = yn[15:0];
                        r.status = ST_DEGEN;
                    end else begin
                        q = ((y - yn) * (longint'(v) - xn)) / den;
                        g = yn + q;
                        if (g > 32767) begin
                            g = 32767;
                            r.status = ST_SAT;
                        end else if (g < -32768) begin
                            g = -32768;
                            r.status = ST_SAT;
                        end
                        r.gain = g[15:0];
                    end
                end
            end
            OP_WR_GAIN: begin
                if (ch >= nc || bd >= nb || lv >= nl) r.status = ST_RANGE;
                else gain_mem[(ch*16+bd)*16+lv] = v;
            end
            OP_WR_BP: begin
                if (lv >= nl) r.status = ST_RANGE;
                else bp_mem[lv] = v;
            end
            default: r.status = ST_RANGE;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_cnt++;
    endtask

    // watch items, config writes and results
    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            for (int k = 0; k < 512; k++) gain_mem[k] = '0;
            for (int k = 0; k < 16; k++) bp_mem[k] = '0;
            levels_cfg = 5'd16;
            bands_cfg = 5'd16;
            chans_cfg = 2'd2;
            expected_q.delete();
            err_cnt = 0;
        end else begin
            if (i_done) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = expected_q.pop_front();
                    if (i_gain !== e.gain)
                        report_mismatch($sformatf("gain %0d expected %0d", i_gain, e.gain));
                    if (i_status !== e.status)
                        report_mismatch($sformatf("status %0d expected %0d", i_status,
                                                  e.status));
                end
            end
            if (i_start && !i_busy)
                expected_q.insert(expected_q.size(),
                                  interpolate_item(t_op'(i_operation), int'(i_channel),
                                                   int'(i_band), int'(i_level_index),
                                                   i_value));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEVELS:   levels_cfg = i_cfg_wdata;
                    CFG_BANDS:    bands_cfg = i_cfg_wdata;
                    CFG_CHANNELS: chans_cfg = i_cfg_wdata[1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[dv/tb_gain_table_level_interpolator_top.sv]
// testbench top of the gain table level interpolator: stimulus and verdict
`timescale 1ns / 1ps
module tb_gain_table_level_interpolator_top;
    import gtli_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              i_operation = '0;
    logic                    i_channel = 1'b0;
    logic [3:0]              i_band = '0;
    logic [3:0]              i_level_index = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    i_cfg_we = 1'b0;
    logic [1:0]              i_cfg_idx = '0;
    logic [CNT_W-1:0]        i_cfg_wdata = '0;
    logic                    o_done;
    logic signed [VAL_W-1:0] o_gain;
    logic [1:0]              o_status;
    int                      errors, pending;
    int                      burst_left;

    always #10 i_clk = ~i_clk;

    gain_table_level_interpolator_top uut (.*);

    gtli_checker chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_operation, .i_channel,
        .i_band, .i_level_index, .i_value, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_done(o_done), .i_gain(o_gain), .i_status(o_status),
        .o_errors(errors), .o_pending(pending)
    );

    // present one item and hold it until accepted, with bursty gaps
    task automatic send_item(t_op op, logic ch, logic [3:0] bd, logic [3:0] lv,
                             logic signed [15:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 30));
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        i_operation <= op;
        i_channel <= ch;
        i_band <= bd;
        i_level_index <= lv;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [4:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for all results, then let stray work drain
    task automatic drain;
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // values: half in -4000..4000, a quarter at the 16-bit extremes, the rest fully random
    function automatic logic signed [15:0] rand_val();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
        endcase
    endfunction

    initial begin
        logic [4:0] lv_set [6] = '{5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd5};
        logic [4:0] bd_set [6] = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd16};
        logic [4:0] ch_set [6] = '{5'd2, 5'd1, 5'd3, 5'd0, 5'd2, 5'd1};
        t_op op;
        burst_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: breakpoints, gains, edge lookups and errors
        for (int k = 0; k < 4; k++) send_item(OP_WR_BP, 0, 0, 4'(k), 16'(k * 256 - 256));
        send_item(OP_WR_GAIN, 0, 0, 0, 16'sh8000);
        send_item(OP_WR_GAIN, 0, 0, 1, 16'sh7fff);
        send_item(OP_WR_GAIN, 1, 15, 15, 16'sh7fff);
        send_item(OP_LOOKUP, 0, 0, 0, 16'sh8000);
        send_item(OP_LOOKUP, 0, 0, 0, 16'sh7fff);
        send_item(OP_LOOKUP, 0, 0, 0, 16'sh0000);
        send_item(OP_LOOKUP, 0, 0, 0, -16'sd128);
        send_item(OP_LOOKUP, 1, 15, 15, 16'sh7fff);
        send_item(OP_WR_BP, 0, 0, 5, 16'sd0);
        send_item(OP_LOOKUP, 0, 0, 0, 16'sh7000);
        send_item(OP_UNKNOWN, 1, 15, 15, 16'shffff);
        drain();
        write_cfg(CFG_LEVELS, 5'd1);
        send_item(OP_LOOKUP, 0, 0, 3, 16'sd5);
        send_item(OP_WR_BP, 0, 0, 1, 16'sd5);
        drain();
        write_cfg(CFG_CHANNELS, 5'd1);
        write_cfg(CFG_BANDS, 5'd2);
        write_cfg(CFG_LEVELS, 5'd16);
        send_item(OP_LOOKUP, 1, 0, 0, 16'sd0);
        send_item(OP_LOOKUP, 0, 2, 0, 16'sd0);
        send_item(OP_WR_GAIN, 1, 1, 0, 16'sd0);
        drain();

        // random phases over several settings
        for (int p = 0; p < 6; p++) begin
            write_cfg(CFG_LEVELS, lv_set[p]);
            write_cfg(CFG_BANDS, bd_set[p]);
            write_cfg(CFG_CHANNELS, ch_set[p]);
            for (int n = 0; n < 180; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: op = OP_LOOKUP;
                    5, 6: op = OP_WR_GAIN;
                    7, 8: op = OP_WR_BP;
                    default: op = t_op'($urandom_range(0, 3));
                endcase
                send_item(op, 1'($urandom()), 4'($urandom()), 4'($urandom()), rand_val());
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hard stop if the handshake hangs
    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
src/gtli_pkg.sv
src/gtli_front.sv
src/gtli_queue.sv
src/gtli_div.sv
src/gtli_back.sv
src/gain_table_level_interpolator_top.sv
dv/gtli_checker.sv
dv/tb_gain_table_level_interpolator_top.sv
